// ===== rtl/mpgco_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// constants, register codes and widths shared by the pixel group cursor overlay
// no dependencies

package mpgco_pkg;

   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 864;
   localparam int BITMAP_LINES  = 2032;
   localparam int CURSOR_DIM    = 16;

   localparam logic [10:0] MAP_MASK = 11'h7FF;

   // cursor row address width
   localparam int ROW_W = $clog2(CURSOR_DIM);

   // csr address map: register i at byte address 4*i
   localparam int REG_COUNT = 5;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam int CSR_ADDR_W = REG_IDX_W + 2;

   localparam logic [REG_IDX_W-1:0] REG_CURSOR_LEFT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CURSOR_TOP     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CURSOR_SHOWN   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CURSOR_OR_MODE = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VIDEO_ON       = 3'd4;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_RENDER = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/mpgco_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// request channel: cursor row loads and pixel group renders
// no dependencies

interface mpgco_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  cursor_row_index;
   logic [15:0] cursor_row_bits;
   logic [9:0]  scan_line;
   logic [6:0]  byte_index;
   logic [10:0] map_entry;
   logic [7:0]  bitmap_byte;

   modport source (output valid, kind, cursor_row_index, cursor_row_bits, scan_line,
                   byte_index, map_entry, bitmap_byte, input ready);
   modport sink (input valid, kind, cursor_row_index, cursor_row_bits, scan_line,
                 byte_index, map_entry, bitmap_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mpgco_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// response channel: rendered pixel groups
// no dependencies

interface mpgco_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_bits;
   logic [9:0] out_line;
   logic [6:0] out_group;

   modport source (output valid, pixel_bits, out_line, out_group, input ready);
   modport sink (input valid, pixel_bits, out_line, out_group, output ready);
endinterface

`default_nettype wire

// ===== rtl/mpgco_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// generic simple dual port ram, one write port and one registered read port
// no dependencies

module mpgco_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mono_pixel_group_cursor_overlay.sv =====
`timescale 1ns / 1ps
`default_nettype none
// monochrome pixel group renderer with a 16x16 hardware cursor overlay
// depends on mpgco_pkg, mpgco_req_if, mpgco_rsp_if and mpgco_ram
//
// usage:
//   req_chan carries two kinds of transfer. a load writes one cursor row into
//   the cursor ram and produces no response. a render carries one bitmap byte
//   and produces one rsp_chan transfer with eight pixels, bit 0 leftmost.
//   the csr port (apb style, pready tied high) holds cursor position, show,
//   merge mode and video enable; write it only while no render is in flight.
// timing:
//   one item per cycle sustained while rsp_chan stays ready. a render passes
//   through the cursor ram read register, then the merge and output register,
//   before it reaches rsp_chan. a load is seen by a render that follows it in
//   the next cycle.
// reset:
//   synchronous reset clears the csr and valid registers and the per-row valid
//   bits, so the cursor image reads as all zero without a clearing pass.
// stall:
//   when rsp_chan is not ready the output register holds and the read stage
//   holds behind it; req_chan stays ready while either stage has room.

module mono_pixel_group_cursor_overlay
   import mpgco_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mpgco_req_if.sink                  req_chan,
   mpgco_rsp_if.source                rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   // configuration registers
   logic [9:0] cursor_left_ff, cursor_left_in;
   logic [9:0] cursor_top_ff, cursor_top_in;
   logic       cursor_shown_ff, cursor_shown_in;
   logic       cursor_or_mode_ff, cursor_or_mode_in;
   logic       video_on_ff, video_on_in;

   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cursor_left_in    = cursor_left_ff;
      cursor_top_in     = cursor_top_ff;
      cursor_shown_in   = cursor_shown_ff;
      cursor_or_mode_in = cursor_or_mode_ff;
      video_on_in       = video_on_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CURSOR_LEFT:    cursor_left_in    = csr_pwdata[9:0];
            REG_CURSOR_TOP:     cursor_top_in     = csr_pwdata[9:0];
            REG_CURSOR_SHOWN:   cursor_shown_in   = csr_pwdata[0];
            REG_CURSOR_OR_MODE: cursor_or_mode_in = csr_pwdata[0];
            REG_VIDEO_ON:       video_on_in       = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CURSOR_LEFT:    csr_prdata = {22'd0, cursor_left_ff};
         REG_CURSOR_TOP:     csr_prdata = {22'd0, cursor_top_ff};
         REG_CURSOR_SHOWN:   csr_prdata = {31'd0, cursor_shown_ff};
         REG_CURSOR_OR_MODE: csr_prdata = {31'd0, cursor_or_mode_ff};
         REG_VIDEO_ON:       csr_prdata = {31'd0, video_on_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // pipeline handshake
   logic req_xfer;
   logic load_xfer;
   logic render_xfer;
   logic out_free;
   logic s1_adv;

   logic       s1_valid_ff, s1_valid_in;
   logic [9:0] s1_line_ff;
   logic [6:0] s1_group_ff;
   logic [7:0] s1_pix_ff;
   logic       s1_hit_ff;
   logic       s1_blank_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pix_ff;
   logic [9:0] rsp_line_ff;
   logic [6:0] rsp_group_ff;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign load_xfer      = req_xfer && (req_chan.kind == KIND_LOAD);
   assign render_xfer    = req_xfer && (req_chan.kind == KIND_RENDER);

   // cursor ram and per-row valid bits
   logic [CURSOR_DIM-1:0] row_valid_ff, row_valid_in;
   logic [CURSOR_DIM-1:0] crow_rd;
   logic                  load_row_ok;
   logic [10:0]           row_diff;
   logic                  in_window;
   logic [ROW_W-1:0]      rd_row;

   assign load_row_ok = {1'b0, req_chan.cursor_row_index} < 5'(CURSOR_DIM);
   assign row_diff    = {1'b0, req_chan.scan_line} - {1'b0, cursor_top_ff};
   assign in_window   = !row_diff[10] && (row_diff < 11'(CURSOR_DIM));
   assign rd_row      = row_diff[ROW_W-1:0];

   always_comb begin
      row_valid_in = row_valid_ff;
      if (load_xfer && load_row_ok) begin
         row_valid_in[req_chan.cursor_row_index[ROW_W-1:0]] = 1'b1;
      end
   end

   mpgco_ram #(
      .WIDTH (CURSOR_DIM),
      .DEPTH (CURSOR_DIM)
   ) u_cursor_ram (
      .clock   (clock),
      .wr_en   (load_xfer && load_row_ok),
      .wr_addr (req_chan.cursor_row_index[ROW_W-1:0]),
      .wr_data (req_chan.cursor_row_bits[CURSOR_DIM-1:0]),
      .rd_en   (render_xfer),
      .rd_addr (rd_row),
      .rd_data (crow_rd)
   );

   // read stage: base pixels and cursor hit, decided while the row is fetched
   logic       map_past;
   logic       line_off;
   logic [7:0] base_pix;

   assign map_past = {1'b0, req_chan.map_entry & MAP_MASK} >= 12'(BITMAP_LINES);
   assign line_off = {3'd0, req_chan.scan_line} >= 13'(SCREEN_HEIGHT);
   assign base_pix = map_past ? 8'd0 : req_chan.bitmap_byte;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (render_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (render_xfer) begin
         s1_line_ff  <= req_chan.scan_line;
         s1_group_ff <= req_chan.byte_index;
         s1_pix_ff   <= base_pix;
         s1_hit_ff   <= cursor_shown_ff && in_window && row_valid_ff[rd_row];
         s1_blank_ff <= !video_on_ff || line_off;
      end
   end

   // merge stage: overlay cursor row, clip at screen edge, apply blanking
   logic [7:0]  merged_pix;
   logic [12:0] px_x;
   logic [12:0] px_col;
   logic        col_ok;
   logic        x_on;
   logic        cbit;

   always_comb begin
      merged_pix = s1_pix_ff;
      px_x       = 13'd0;
      px_col     = 13'd0;
      col_ok     = 1'b0;
      x_on       = 1'b0;
      cbit       = 1'b0;
      for (int k = 0; k < 8; k++) begin
         px_x   = {3'd0, s1_group_ff, 3'd0} + 13'(k);
         px_col = px_x - {3'd0, cursor_left_ff};
         col_ok = !px_col[12] && (px_col < 13'(CURSOR_DIM));
         x_on   = px_x < 13'(SCREEN_WIDTH);
         cbit   = crow_rd[px_col[ROW_W-1:0]];
         if (s1_hit_ff && col_ok && x_on) begin
            if (cursor_or_mode_ff) begin
               merged_pix[k] = merged_pix[k] | cbit;
            end else if (cbit) begin
               merged_pix[k] = 1'b0;
            end
         end
         if (!x_on) begin
            merged_pix[k] = 1'b0;
         end
      end
      if (s1_blank_ff) begin
         merged_pix = 8'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pix_ff   <= merged_pix;
         rsp_line_ff  <= s1_line_ff;
         rsp_group_ff <= s1_group_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pixel_bits = rsp_pix_ff;
   assign rsp_chan.out_line   = rsp_line_ff;
   assign rsp_chan.out_group  = rsp_group_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_left_ff    <= 10'd0;
         cursor_top_ff     <= 10'd0;
         cursor_shown_ff   <= 1'b0;
         cursor_or_mode_ff <= 1'b0;
         video_on_ff       <= 1'b0;
         row_valid_ff      <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cursor_left_ff    <= cursor_left_in;
         cursor_top_ff     <= cursor_top_in;
         cursor_shown_ff   <= cursor_shown_in;
         cursor_or_mode_ff <= cursor_or_mode_in;
         video_on_ff       <= video_on_in;
         row_valid_ff      <= row_valid_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mpgco_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// port level checks for the pixel group cursor overlay, with its bind
// depends on mpgco_pkg and mono_pixel_group_cursor_overlay

module mpgco_checker
   import mpgco_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_kind,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel_bits,
   input wire logic [9:0] rsp_out_line,
   input wire logic [6:0] rsp_out_group
);

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_bits) &&
         $stable(rsp_out_line) && $stable(rsp_out_group))
      else $error("stalled response changed");

   // a render transfer leads to a valid response when the sink is ready while the render sits in the read stage
   a_render_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == KIND_RENDER) ##1 rsp_ready |=> rsp_valid)
      else $error("render transfer did not reach the response");

   // lines below the screen are always blank
   a_off_screen_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({3'd0, rsp_out_line} >= 13'(SCREEN_HEIGHT)) |-> rsp_pixel_bits == 8'd0)
      else $error("pixels on a line below the screen");

endmodule

bind mono_pixel_group_cursor_overlay mpgco_checker u_mpgco_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_kind       (req_chan.kind),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pixel_bits (rsp_chan.pixel_bits),
   .rsp_out_line   (rsp_chan.out_line),
   .rsp_out_group  (rsp_chan.out_group)
);

`default_nettype wire
